// File: hw/rtl/tte_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_pkg
// Shared types, character codes and helpers for the equation token escaper.
// ----------------------------------------------------------------------------
package tte_pkg;

  // size of the per-item byte string
  localparam int OUT_MAX  = 20;
  localparam int CORE_MAX = 13;
  localparam int PRE_MAX  = 4;
  localparam int OUT_CNT_W = $clog2(OUT_MAX + 1);
  localparam int CORE_CNT_W = $clog2(CORE_MAX + 1);
  localparam int PRE_CNT_W = $clog2(PRE_MAX + 1);
  localparam int COUNT_W  = 10;

  typedef logic [OUT_MAX-1:0][7:0]  byte_buf_t;
  typedef logic [CORE_MAX-1:0][7:0] core_t;
  typedef logic [PRE_MAX-1:0][7:0]  pre_t;

  typedef enum logic [1:0] {
    FONT_NONE = 2'd0,
    FONT_ROM  = 2'd1,
    FONT_ITAL = 2'd2
  } font_t;

  // backslash escape pass-through phases
  typedef enum logic [2:0] {
    ESC_IDLE = 3'd0,
    ESC_KIND = 3'd1,
    ESC_ARG  = 3'd2,
    ESC_LAST = 3'd3,
    ESC_NAME = 3'd4
  } esc_phase_t;

  typedef struct packed {
    font_t      prev_font;
    font_t      lead_font;
    logic [7:0] held_char;
    logic       held_valid;
    esc_phase_t escape_phase;
    logic [7:0] escape_kind;
  } tok_state_t;

  localparam tok_state_t TOK_RESET = '{
    prev_font:    FONT_NONE,
    lead_font:    FONT_NONE,
    held_char:    8'h00,
    held_valid:   1'b0,
    escape_phase: ESC_IDLE,
    escape_kind:  8'h00
  };

  typedef struct packed {
    logic       italic_mode;
    logic [7:0] roman_code;
    logic [7:0] italic_code;
  } cfg_t;

  // register map, word index
  localparam logic [1:0] REG_ITALIC_MODE = 2'd0;
  localparam logic [1:0] REG_ROMAN_CODE  = 2'd1;
  localparam logic [1:0] REG_ITALIC_CODE = 2'd2;

  localparam logic [7:0] ROMAN_CODE_RST  = 8'd49;
  localparam logic [7:0] ITALIC_CODE_RST = 8'd50;

  // character codes
  localparam logic [7:0] CH_BSL   = 8'h5c;
  localparam logic [7:0] CH_PIPE  = 8'h7c;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5b;
  localparam logic [7:0] CH_RBRK  = 8'h5d;
  localparam logic [7:0] CH_LT    = 8'h3c;
  localparam logic [7:0] CH_GT    = 8'h3e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_EQ    = 8'h3d;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_TILDE = 8'h7e;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_CARET = 8'h5e;
  localparam logic [7:0] CH_QUOTE = 8'h27;
  localparam logic [7:0] CH_STAR  = 8'h2a;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_SEMI  = 8'h3b;
  localparam logic [7:0] CH_BANG  = 8'h21;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_DIG0  = 8'h30;
  localparam logic [7:0] CH_DIG9  = 8'h39;
  localparam logic [7:0] CH_LC_F  = 8'h66;
  localparam logic [7:0] CH_LC_J  = 8'h6a;
  localparam logic [7:0] CH_LC_E  = 8'h65;
  localparam logic [7:0] CH_LC_Q  = 8'h71;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_LC_L  = 8'h6c;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_M  = 8'h6d;
  localparam logic [7:0] CH_LC_I  = 8'h69;
  localparam logic [7:0] CH_UC_P  = 8'h50;

  // c wrapped in a roman font change and a font restore
  function automatic core_t roman_wrap(input logic [7:0] c, input logic [7:0] code);
    core_t r;
    r    = '0;
    r[0] = CH_BSL;
    r[1] = CH_LC_F;
    r[2] = code;
    r[3] = c;
    r[4] = CH_BSL;
    r[5] = CH_LC_F;
    r[6] = CH_UC_P;
    return r;
  endfunction

  // two-letter character name
  function automatic pre_t char_name(input logic [7:0] a, input logic [7:0] b);
    pre_t r;
    r[0] = CH_BSL;
    r[1] = CH_LPAR;
    r[2] = a;
    r[3] = b;
    return r;
  endfunction

endpackage

// File: hw/rtl/tte_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_in_if
// Input channel: one token byte per transaction with an end-of-token mark.
// ----------------------------------------------------------------------------
interface tte_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_in;
  logic       token_end;

  modport source (output valid, output char_in, output token_end, input ready);
  modport sink (input valid, input char_in, input token_end, output ready);
endinterface

// File: hw/rtl/tte_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_out_if
// Result channel: one converted byte per transaction with token-end status.
// ----------------------------------------------------------------------------
interface tte_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] first_font;
  logic [1:0] last_font;
  logic       too_long;

  modport source (output valid, output out_byte, output out_last, output first_font,
                  output last_font, output too_long, input ready);
  modport sink (input valid, input out_byte, input out_last, input first_font,
                input last_font, input too_long, output ready);
endinterface

// File: hw/rtl/tte_expand.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tte_expand
// Expands one token byte into its escape string and the next token state.
// ----------------------------------------------------------------------------
module tte_expand (
  input  tte_pkg::cfg_t       cfg,
  input  tte_pkg::tok_state_t st,
  input  logic [7:0]          char_in,
  input  logic                token_end,
  output tte_pkg::tok_state_t st_nxt,
  output tte_pkg::byte_buf_t  bytes,
  output logic [tte_pkg::OUT_CNT_W-1:0] n_bytes
);
  import tte_pkg::*;

  pre_t                  pre;
  logic [PRE_CNT_W-1:0]  pl;
  core_t                 core;
  logic [CORE_CNT_W-1:0] cl;
  logic                  proc;
  logic                  thin_class;
  logic                  roman_class;
  logic                  ital_prev;
  font_t                 f;
  byte_buf_t             pre_ext;
  byte_buf_t             core_ext;

  assign ital_prev = (st.prev_font == FONT_ITAL);

  // digits and punctuation set in roman
  assign roman_class = (char_in >= CH_DIG0 && char_in <= CH_DIG9) ||
                       char_in == CH_COLON || char_in == CH_SEMI ||
                       char_in == CH_BANG || char_in == CH_PCT ||
                       char_in == CH_LPAR || char_in == CH_LBRK ||
                       char_in == CH_RPAR || char_in == CH_RBRK;

  // items preceded by a thin space after italic text
  assign thin_class = roman_class || char_in == CH_PIPE || char_in == CH_EQ ||
                      char_in == CH_PLUS || char_in == CH_SLASH ||
                      char_in == CH_LT || char_in == CH_GT ||
                      char_in == CH_MINUS || char_in == CH_BSL;

  // per-byte decode: prefix segment plus core segment
  always_comb begin
    pre    = '0;
    pl     = '0;
    core   = '0;
    cl     = '0;
    proc   = 1'b0;
    f      = FONT_ROM;
    st_nxt = st;

    if (st.escape_phase != ESC_IDLE) begin
      // escape pass-through
      core[0] = char_in;
      cl      = CORE_CNT_W'(1);
      case (st.escape_phase)
        ESC_KIND: begin
          st_nxt.escape_kind  = char_in;
          st_nxt.escape_phase = ESC_ARG;
        end
        ESC_ARG: begin
          if (st.escape_kind == CH_LPAR) begin
            st_nxt.escape_phase = ESC_LAST;
          end else if (st.escape_kind == CH_STAR && char_in == CH_LPAR) begin
            st_nxt.escape_phase = ESC_NAME;
          end else begin
            st_nxt.escape_phase = ESC_IDLE;
          end
        end
        ESC_NAME: st_nxt.escape_phase = ESC_LAST;
        default:  st_nxt.escape_phase = ESC_IDLE;
      endcase
    end else if (st.held_valid) begin
      // resolve the held '<', '>' or '-'
      st_nxt.held_valid = 1'b0;
      if ((st.held_char == CH_LT || st.held_char == CH_GT) && char_in == CH_EQ) begin
        pre = char_name(st.held_char, CH_EQ);
        pl  = PRE_CNT_W'(4);
      end else if (st.held_char == CH_MINUS && char_in == CH_GT) begin
        pre = char_name(CH_MINUS, CH_GT);
        pl  = PRE_CNT_W'(4);
      end else begin
        if (st.held_char == CH_MINUS) begin
          pre = char_name(CH_LC_M, CH_LC_I);
          pl  = PRE_CNT_W'(4);
        end else begin
          pre[0] = st.held_char;
          pl     = PRE_CNT_W'(1);
        end
        proc = 1'b1;
      end
    end else begin
      proc = 1'b1;
    end

    if (proc) begin
      // a held byte leaves prev_font roman, so prefix never collides here
      if (ital_prev && thin_class) begin
        pre[0] = CH_BSL;
        pre[1] = CH_PIPE;
        pl     = PRE_CNT_W'(2);
      end

      if (roman_class) begin
        core = roman_wrap(char_in, cfg.roman_code);
        cl   = CORE_CNT_W'(7);
      end else if (char_in == CH_DOT) begin
        if (st.prev_font == FONT_ROM) begin
          core = roman_wrap(char_in, cfg.roman_code);
          cl   = CORE_CNT_W'(7);
        end else begin
          core[0] = char_in;
          cl      = CORE_CNT_W'(1);
        end
        f = st.prev_font;
      end else if (char_in == CH_PIPE) begin
        core[0]  = CH_BSL;
        core[1]  = CH_PIPE;
        core[2]  = CH_BSL;
        core[3]  = CH_LC_F;
        core[4]  = cfg.roman_code;
        core[5]  = CH_PIPE;
        core[6]  = CH_BSL;
        core[7]  = CH_LC_F;
        core[8]  = CH_UC_P;
        core[9]  = CH_BSL;
        core[10] = CH_PIPE;
        cl       = CORE_CNT_W'(11);
      end else if (char_in == CH_EQ || char_in == CH_PLUS || char_in == CH_SLASH) begin
        core[0] = CH_BSL;
        core[1] = CH_LPAR;
        core[2] = (char_in == CH_EQ) ? CH_LC_E :
                  (char_in == CH_PLUS) ? CH_LC_P : CH_LC_S;
        core[3] = (char_in == CH_EQ) ? CH_LC_Q : CH_LC_L;
        cl      = CORE_CNT_W'(4);
      end else if (char_in == CH_LT || char_in == CH_GT || char_in == CH_MINUS) begin
        if (token_end) begin
          if (char_in == CH_MINUS) begin
            core[0] = CH_BSL;
            core[1] = CH_LPAR;
            core[2] = CH_LC_M;
            core[3] = CH_LC_I;
            cl      = CORE_CNT_W'(4);
          end else begin
            core[0] = char_in;
            cl      = CORE_CNT_W'(1);
          end
        end else begin
          st_nxt.held_char  = char_in;
          st_nxt.held_valid = 1'b1;
        end
      end else if (char_in == CH_TILDE || char_in == CH_SPACE) begin
        core[0] = CH_BSL;
        core[1] = CH_PIPE;
        core[2] = CH_BSL;
        core[3] = CH_PIPE;
        cl      = CORE_CNT_W'(4);
      end else if (char_in == CH_CARET) begin
        core[0] = CH_BSL;
        core[1] = CH_PIPE;
        cl      = CORE_CNT_W'(2);
      end else if (char_in == CH_BSL) begin
        core[0]             = char_in;
        cl                  = CORE_CNT_W'(1);
        st_nxt.escape_phase = ESC_KIND;
      end else if (char_in == CH_QUOTE) begin
        core[0] = CH_BSL;
        core[1] = CH_LC_F;
        core[2] = ital_prev ? cfg.italic_code : cfg.roman_code;
        core[3] = CH_BSL;
        core[4] = CH_LPAR;
        core[5] = CH_LC_F;
        core[6] = CH_LC_M;
        core[7] = CH_BSL;
        core[8] = CH_LC_F;
        core[9] = CH_UC_P;
        cl      = CORE_CNT_W'(10);
        f       = ital_prev ? FONT_ITAL : FONT_ROM;
      end else if (char_in == CH_LC_F && cfg.italic_mode) begin
        core[0] = CH_BSL;
        core[1] = CH_CARET;
        core[2] = CH_LC_F;
        core[3] = CH_BSL;
        core[4] = CH_CARET;
        cl      = CORE_CNT_W'(5);
        f       = FONT_ITAL;
      end else if (char_in == CH_LC_J && cfg.italic_mode) begin
        core[0] = CH_BSL;
        core[1] = CH_CARET;
        core[2] = CH_LC_J;
        cl      = CORE_CNT_W'(3);
        f       = FONT_ITAL;
      end else if (char_in == CH_LC_F || char_in == CH_LC_J) begin
        core[0] = char_in;
        cl      = CORE_CNT_W'(1);
      end else begin
        core[0] = char_in;
        cl      = CORE_CNT_W'(1);
        f       = cfg.italic_mode ? FONT_ITAL : FONT_ROM;
      end

      // font bookkeeping
      st_nxt.prev_font = f;
      if (st.lead_font == FONT_NONE) begin
        st_nxt.lead_font = f;
      end
    end
  end

  // join prefix and core into one byte string
  assign pre_ext  = {{((OUT_MAX - PRE_MAX) * 8){1'b0}}, pre};
  assign core_ext = {{((OUT_MAX - CORE_MAX) * 8){1'b0}}, core};
  assign bytes    = (core_ext << {pl, 3'b000}) | pre_ext;
  assign n_bytes  = OUT_CNT_W'(pl) + OUT_CNT_W'(cl);

endmodule

// File: hw/rtl/typeset_token_escaper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// typeset_token_escaper
// Converts equation token bytes into typesetter escape strings.
// ----------------------------------------------------------------------------
// Each accepted token byte is expanded into its escape string (0 to 15 bytes),
// which leaves the result channel one byte per transaction; the output shift
// register sends one byte per cycle while out_chan.ready is high. The next
// input byte is loaded in the same cycle that the last byte of the previous
// string is taken. first_font, last_font and too_long are valid on the
// transaction that carries out_last and read zero otherwise. Registers:
// italic_mode at 0x0, roman_code at 0x4, italic_code at 0x8; write them only
// while the block is idle.
module typeset_token_escaper #(
  parameter int MAX_OUT_LEN = 400
) (
  input  logic        clk,
  input  logic        rst_n,
  tte_in_if.sink      in_chan,
  tte_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import tte_pkg::*;

  logic                 italic_mode_r;
  logic [7:0]           roman_code_r;
  logic [7:0]           italic_code_r;
  cfg_t                 cfg;
  logic                 cfg_wr;

  logic                 in_valid_r;
  logic [7:0]           in_char_r;
  logic                 in_end_r;

  tok_state_t           st_r;
  tok_state_t           st_nxt;
  logic [COUNT_W-1:0]   count_r;
  logic [COUNT_W-1:0]   count_nxt;
  logic [COUNT_W:0]     count_sum;
  logic                 over_r;
  logic                 over_nxt;

  byte_buf_t            exp_bytes;
  logic [OUT_CNT_W-1:0] exp_n;

  byte_buf_t            buf_r;
  logic [OUT_CNT_W-1:0] len_r;
  logic                 last_r;
  logic [1:0]           first_font_r;
  logic [1:0]           last_font_r;
  logic                 too_long_r;

  logic                 load;
  logic                 take;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      italic_mode_r <= 1'b0;
      roman_code_r  <= ROMAN_CODE_RST;
      italic_code_r <= ITALIC_CODE_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_ITALIC_MODE: italic_mode_r <= pwdata[0];
        REG_ROMAN_CODE:  roman_code_r  <= pwdata[7:0];
        REG_ITALIC_CODE: italic_code_r <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_ITALIC_MODE: prdata = {31'd0, italic_mode_r};
      REG_ROMAN_CODE:  prdata = {24'd0, roman_code_r};
      REG_ITALIC_CODE: prdata = {24'd0, italic_code_r};
      default:         prdata = 32'd0;
    endcase
  end

  assign cfg = '{italic_mode: italic_mode_r, roman_code: roman_code_r,
                 italic_code: italic_code_r};

  // handshake: load the expansion when the shift register frees up
  assign take = out_chan.valid & out_chan.ready;
  assign load = in_valid_r &&
                (len_r == '0 || (len_r == OUT_CNT_W'(1) && out_chan.ready));
  assign in_chan.ready = !in_valid_r || load;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready) begin
      in_char_r <= in_chan.char_in;
      in_end_r  <= in_chan.token_end;
    end
  end

  // byte expansion
  tte_expand u_expand (
    .cfg       (cfg),
    .st        (st_r),
    .char_in   (in_char_r),
    .token_end (in_end_r),
    .st_nxt    (st_nxt),
    .bytes     (exp_bytes),
    .n_bytes   (exp_n)
  );

  // saturating output length and overflow flag
  assign count_sum = {1'b0, count_r} + (COUNT_W + 1)'(exp_n);
  assign count_nxt = count_sum[COUNT_W] ? {COUNT_W{1'b1}} : count_sum[COUNT_W-1:0];
  assign over_nxt  = over_r | (count_nxt > COUNT_W'(MAX_OUT_LEN));

  // token state, cleared at token end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= TOK_RESET;
      count_r <= '0;
      over_r  <= 1'b0;
    end else if (load) begin
      if (in_end_r) begin
        st_r    <= TOK_RESET;
        count_r <= '0;
        over_r  <= 1'b0;
      end else begin
        st_r    <= st_nxt;
        count_r <= count_nxt;
        over_r  <= over_nxt;
      end
    end
  end

  // output shift register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= '0;
    end else if (load) begin
      len_r <= exp_n;
    end else if (take) begin
      len_r <= len_r - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_r        <= exp_bytes;
      last_r       <= in_end_r;
      first_font_r <= st_nxt.lead_font;
      last_font_r  <= st_nxt.prev_font;
      too_long_r   <= over_nxt;
    end else if (take) begin
      buf_r <= buf_r >> 8;
    end
  end

  assign out_chan.valid      = (len_r != '0);
  assign out_chan.out_byte   = buf_r[0];
  assign out_chan.out_last   = last_r && (len_r == OUT_CNT_W'(1));
  assign out_chan.first_font = out_chan.out_last ? first_font_r : 2'd0;
  assign out_chan.last_font  = out_chan.out_last ? last_font_r : 2'd0;
  assign out_chan.too_long   = out_chan.out_last ? too_long_r : 1'b0;

  // checks
  a_held_vs_escape: assert property (@(posedge clk) disable iff (!rst_n)
    !(st_r.held_valid && st_r.escape_phase != ESC_IDLE))
    else $error("held byte and escape active together");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= OUT_CNT_W'(OUT_MAX))
    else $error("output string length out of range");

  a_token_clear: assert property (@(posedge clk) disable iff (!rst_n)
    load && in_end_r |=> st_r == TOK_RESET && count_r == '0 && !over_r)
    else $error("token state not cleared after token end");

  a_over_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    over_r && !(load && in_end_r) |=> over_r)
    else $error("overflow flag dropped inside a token");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid_r && !load |=> in_valid_r && $stable(in_char_r) && $stable(in_end_r))
    else $error("pending input byte lost");

endmodule

// File: tb/sv/escape_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// escape_checker
// Watches the token escaper's channels, predicts each converted byte and
// compares it field by field with what the block emits.
// ----------------------------------------------------------------------------
module escape_checker #(
  parameter int MAX_OUT_LEN = 400
) (
  input  logic        clk,
  input  logic        rst_n,
  tte_in_if           in_mon,
  tte_out_if          out_mon,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output int          fail_count,
  output int          pending
);
  import tte_pkg::*;

  localparam int unsigned COUNT_SAT = 1023;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    logic [1:0] first_font;
    logic [1:0] last_font;
    logic       too_long;
  } esc_byte_t;

  // shadow of the register file
  cfg_t cfg;

  // token state
  font_t       prev_font;
  font_t       lead_font;
  logic [7:0]  held_char;
  logic        held_valid;
  esc_phase_t  esc_phase;
  logic [7:0]  esc_kind;
  int unsigned emitted;
  logic        overflow;

  // string produced by the current transaction, and the bytes still owed
  logic [7:0] expansion[$];
  esc_byte_t  expected_bytes[$];

  function automatic void put(input logic [7:0] b);
    expansion.push_back(b);
  endfunction

  function automatic void put_thin();
    put(CH_BSL);
    put(CH_PIPE);
  endfunction

  function automatic void thin_after_italic();
    if (prev_font == FONT_ITAL) put_thin();
  endfunction

  function automatic void put_name(input logic [7:0] a, input logic [7:0] b);
    put(CH_BSL);
    put(CH_LPAR);
    put(a);
    put(b);
  endfunction

  function automatic void put_roman(input logic [7:0] c);
    put(CH_BSL);
    put(CH_LC_F);
    put(cfg.roman_code);
    put(c);
    put(CH_BSL);
    put(CH_LC_F);
    put(CH_UC_P);
  endfunction

  function automatic void put_held(input logic [7:0] c);
    if (c == CH_MINUS) put_name(CH_LC_M, CH_LC_I);
    else put(c);
  endfunction

  // expansion of one byte outside any escape or look-ahead
  function automatic void convert(input logic [7:0] c, input logic last);
    font_t f;
    f = FONT_ROM;
    if ((c >= CH_DIG0 && c <= CH_DIG9) || c == CH_COLON || c == CH_SEMI ||
        c == CH_BANG || c == CH_PCT || c == CH_LPAR || c == CH_LBRK ||
        c == CH_RPAR || c == CH_RBRK) begin
      thin_after_italic();
      put_roman(c);
    end else begin
      case (c)
        CH_DOT: begin
          if (prev_font == FONT_ROM) put_roman(c);
          else put(c);
          f = prev_font;
        end
        CH_PIPE: begin
          thin_after_italic();
          put_thin();
          put_roman(c);
          put_thin();
        end
        CH_EQ: begin
          thin_after_italic();
          put_name(CH_LC_E, CH_LC_Q);
        end
        CH_PLUS: begin
          thin_after_italic();
          put_name(CH_LC_P, CH_LC_L);
        end
        CH_SLASH: begin
          thin_after_italic();
          put_name(CH_LC_S, CH_LC_L);
        end
        CH_LT, CH_GT, CH_MINUS: begin
          thin_after_italic();
          if (last) begin
            put_held(c);
          end else begin
            held_char  = c;
            held_valid = 1'b1;
          end
        end
        CH_TILDE, CH_SPACE: begin
          put_thin();
          put_thin();
        end
        CH_CARET: put_thin();
        CH_BSL: begin
          thin_after_italic();
          put(c);
          esc_phase = ESC_KIND;
        end
        CH_QUOTE: begin
          put(CH_BSL);
          put(CH_LC_F);
          put(prev_font == FONT_ITAL ? cfg.italic_code : cfg.roman_code);
          put_name(CH_LC_F, CH_LC_M);
          put(CH_BSL);
          put(CH_LC_F);
          put(CH_UC_P);
          f = (prev_font == FONT_ITAL) ? FONT_ITAL : FONT_ROM;
        end
        CH_LC_F: begin
          if (cfg.italic_mode) begin
            put(CH_BSL);
            put(CH_CARET);
            put(CH_LC_F);
            put(CH_BSL);
            put(CH_CARET);
            f = FONT_ITAL;
          end else begin
            put(c);
          end
        end
        CH_LC_J: begin
          if (cfg.italic_mode) begin
            put(CH_BSL);
            put(CH_CARET);
            put(CH_LC_J);
            f = FONT_ITAL;
          end else begin
            put(c);
          end
        end
        default: begin
          put(c);
          f = cfg.italic_mode ? FONT_ITAL : FONT_ROM;
        end
      endcase
    end
    prev_font = f;
    if (lead_font == FONT_NONE) lead_font = f;
  endfunction

  // backslash pass-through
  function automatic void escape_pass(input logic [7:0] c);
    put(c);
    case (esc_phase)
      ESC_KIND: begin
        esc_kind  = c;
        esc_phase = ESC_ARG;
      end
      ESC_ARG: begin
        if (esc_kind == CH_LPAR) esc_phase = ESC_LAST;
        else if (esc_kind == CH_STAR && c == CH_LPAR) esc_phase = ESC_NAME;
        else esc_phase = ESC_IDLE;
      end
      ESC_NAME: esc_phase = ESC_LAST;
      default:  esc_phase = ESC_IDLE;
    endcase
  endfunction

  function automatic void clear_token();
    prev_font  = FONT_NONE;
    lead_font  = FONT_NONE;
    held_char  = 8'h00;
    held_valid = 1'b0;
    esc_phase  = ESC_IDLE;
    esc_kind   = 8'h00;
    emitted    = 0;
    overflow   = 1'b0;
  endfunction

  // expected bytes for one accepted input transaction
  function automatic void predict_bytes(input logic [7:0] c, input logic last);
    logic [7:0] h;
    esc_byte_t  r;
    expansion.delete();
    if (esc_phase != ESC_IDLE) begin
      escape_pass(c);
    end else if (held_valid) begin
      h          = held_char;
      held_valid = 1'b0;
      if ((h == CH_LT || h == CH_GT) && c == CH_EQ) begin
        put_name(h, CH_EQ);
      end else if (h == CH_MINUS && c == CH_GT) begin
        put_name(CH_MINUS, CH_GT);
      end else begin
        put_held(h);
        convert(c, last);
      end
    end else begin
      convert(c, last);
    end

    emitted += expansion.size();
    if (emitted > COUNT_SAT) emitted = COUNT_SAT;
    if (emitted > MAX_OUT_LEN) overflow = 1'b1;

    foreach (expansion[k]) begin
      r.out_byte   = expansion[k];
      r.out_last   = last && (k == expansion.size() - 1);
      r.first_font = r.out_last ? lead_font : FONT_NONE;
      r.last_font  = r.out_last ? prev_font : FONT_NONE;
      r.too_long   = r.out_last ? overflow : 1'b0;
      expected_bytes.push_back(r);
    end
    if (last) clear_token();
  endfunction

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, actual %0h", name, want, got);
      fail_count++;
    end
  endfunction

  // compare, predict and follow register writes at each rising edge
  always @(posedge clk) begin
    esc_byte_t want;
    if (!rst_n) begin
      cfg.italic_mode = 1'b0;
      cfg.roman_code  = ROMAN_CODE_RST;
      cfg.italic_code = ITALIC_CODE_RST;
      clear_token();
      expected_bytes.delete();
      fail_count = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected transaction: out_byte %0h", out_mon.out_byte);
          fail_count++;
        end else begin
          want = expected_bytes.pop_front();
          check_field("out_byte", want.out_byte, out_mon.out_byte);
          check_field("out_last", 8'(want.out_last), 8'(out_mon.out_last));
          check_field("first_font", 8'(want.first_font), 8'(out_mon.first_font));
          check_field("last_font", 8'(want.last_font), 8'(out_mon.last_font));
          check_field("too_long", 8'(want.too_long), 8'(out_mon.too_long));
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict_bytes(in_mon.char_in, in_mon.token_end);
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_ITALIC_MODE: cfg.italic_mode = pwdata[0];
          REG_ROMAN_CODE:  cfg.roman_code  = pwdata[7:0];
          REG_ITALIC_CODE: cfg.italic_code = pwdata[7:0];
          default: ;
        endcase
      end
    end
    pending = expected_bytes.size();
  end

endmodule

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Token escaper test: directed tokens for several character classes and the
// look-ahead, escape and font corner cases, then random tokens under several
// register settings and handshake idling patterns, checked by escape_checker.
// ----------------------------------------------------------------------------
module testbench;
  import tte_pkg::*;

  localparam int MAX_OUT_LEN   = 400;
  localparam int PHASE_ITEMS   = 36;
  localparam int SETTLE_CYCLES = 30;
  localparam int STALL_LIMIT   = 4000;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  int          fail_count;
  int          pending;

  int          send_idle_pct;
  int          recv_stall_pct;
  int          bytes_sent;
  int          quiet_cycles;
  logic [7:0]  token_bytes[$];

  tte_in_if  in_chan ();
  tte_out_if out_chan ();

  typeset_token_escaper #(.MAX_OUT_LEN(MAX_OUT_LEN)) dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  escape_checker #(.MAX_OUT_LEN(MAX_OUT_LEN)) checker_i (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_mon    (in_chan),
    .out_mon   (out_chan),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .pready    (pready),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .fail_count(fail_count),
    .pending   (pending)
  );

  // 2 ns clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result channel back-pressure
  always @(negedge clk) begin
    out_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // abort when nothing moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) ||
        psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_fonts(input logic ital, input logic [7:0] roman, input logic [7:0] italic);
    write_reg(REG_ITALIC_MODE, {31'd0, ital});
    write_reg(REG_ROMAN_CODE, {24'd0, roman});
    write_reg(REG_ITALIC_CODE, {24'd0, italic});
  endtask

  // one input transaction, with random sender gaps in front of it
  task automatic send_byte(input logic [7:0] c, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(negedge clk);
    end
    in_chan.valid     <= 1'b1;
    in_chan.char_in   <= c;
    in_chan.token_end <= last;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], i == s.len() - 1);
  endtask

  task automatic send_token();
    foreach (token_bytes[i]) send_byte(token_bytes[i], i == token_bytes.size() - 1);
    in_chan.valid <= 1'b0;
  endtask

  // wait until every owed byte has come out and the block has settled
  task automatic drain();
    in_chan.valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  function automatic logic [7:0] pick_symbol();
    case ($urandom_range(17))
      0:  return CH_COLON;
      1:  return CH_SEMI;
      2:  return CH_BANG;
      3:  return CH_PCT;
      4:  return CH_LPAR;
      5:  return CH_LBRK;
      6:  return CH_RPAR;
      7:  return CH_RBRK;
      8:  return CH_DOT;
      9:  return CH_PIPE;
      10: return CH_EQ;
      11: return CH_PLUS;
      12: return CH_SLASH;
      13: return CH_TILDE;
      14: return CH_SPACE;
      15: return CH_CARET;
      16: return CH_QUOTE;
      default: return CH_STAR;
    endcase
  endfunction

  function automatic logic [7:0] pick_letter();
    return 8'(8'h61 + $urandom_range(25));
  endfunction

  // mostly well-formed equation tokens, some noise and cut-off endings
  task automatic build_token();
    int n;
    int cut;
    logic [7:0] op;
    token_bytes.delete();
    n = $urandom_range(1, 8);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(9))
        0, 1: token_bytes.push_back(pick_letter());
        2:    token_bytes.push_back(8'(CH_DIG0 + $urandom_range(9)));
        3, 4: token_bytes.push_back(pick_symbol());
        5: begin
          case ($urandom_range(2))
            0:       op = CH_LT;
            1:       op = CH_GT;
            default: op = CH_MINUS;
          endcase
          token_bytes.push_back(op);
          if ($urandom_range(1)) token_bytes.push_back(op == CH_MINUS ? CH_GT : CH_EQ);
        end
        6: begin
          token_bytes.push_back(CH_BSL);
          case ($urandom_range(3))
            0: begin
              token_bytes.push_back(CH_LPAR);
              token_bytes.push_back(8'($urandom_range(255)));
              token_bytes.push_back(8'($urandom_range(255)));
            end
            1: begin
              token_bytes.push_back(CH_STAR);
              token_bytes.push_back(CH_LPAR);
              token_bytes.push_back(pick_letter());
              token_bytes.push_back(pick_letter());
            end
            2: begin
              token_bytes.push_back(CH_STAR);
              token_bytes.push_back(8'($urandom_range(255)));
            end
            default: begin
              token_bytes.push_back(8'($urandom_range(255)));
              token_bytes.push_back(8'($urandom_range(255)));
            end
          endcase
        end
        7: token_bytes.push_back(8'($urandom_range(255)));
        8: token_bytes.push_back($urandom_range(1) ? CH_LC_F : CH_LC_J);
        default: token_bytes.push_back($urandom_range(1) ? CH_QUOTE : CH_DOT);
      endcase
    end
    // cut the token short now and then, often in the middle of a sequence
    if ($urandom_range(7) == 0 && token_bytes.size() > 1) begin
      cut = $urandom_range(1, token_bytes.size() - 1);
      repeat (cut) void'(token_bytes.pop_back());
    end
  endtask

  initial begin
    int start_count;
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_chan.valid     = 1'b0;
    in_chan.char_in   = 8'h00;
    in_chan.token_end = 1'b0;
    out_chan.ready    = 1'b0;
    send_idle_pct     = 0;
    recv_stall_pct    = 0;
    bytes_sent        = 0;
    quiet_cycles      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: reset fonts, roman text
    send_text(".");
    send_text("<=");
    send_text("->");
    send_text("-");
    send_text(">x");
    send_text("\\(ab");
    send_text("\\*(xy");
    send_text("\\(");
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b1);
    drain();

    // directed: italic mode with extreme selector codes
    set_fonts(1'b1, 8'h00, 8'hff);
    send_text("f'j|.");
    send_text("=+/ ^");
    drain();

    // random tokens: settings and idling change per phase
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin
          set_fonts(1'b0, 8'hff, 8'h00);
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          set_fonts(1'b1, 8'($urandom_range(255)), 8'($urandom_range(255)));
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          set_fonts(1'b0, 8'($urandom_range(255)), 8'($urandom_range(255)));
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          set_fonts(1'b1, ROMAN_CODE_RST, ITALIC_CODE_RST);
          send_idle_pct  = 13;
          recv_stall_pct = 13;
        end
      endcase
      start_count = bytes_sent;
      // one token long enough to exceed the output length limit
      if (ph == 2) begin
        token_bytes.delete();
        repeat (40) token_bytes.push_back(CH_PIPE);
        send_token();
      end
      while (bytes_sent - start_count < PHASE_ITEMS) begin
        build_token();
        send_token();
      end
      drain();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
